// File: rtl/cft_pkg.sv
// Shared types and constants for the CSV field tokenizer.
package cft_pkg;

  typedef enum logic [1:0] {
    MODE_OUTSIDE = 2'd0,
    MODE_INSIDE  = 2'd1,
    MODE_PENDING = 2'd2
  } quote_mode_e;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_EOR  = 1'b1
  } cmd_e;

  localparam logic [7:0] QUOTE_BYTE  = 8'h22;
  localparam logic [7:0] DELIM_RESET = 8'd44;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       field_end;
    logic       record_end;
  } result_t;

endpackage

// File: rtl/cft_stream_if.sv
// Request and result channel interfaces for the CSV field tokenizer.
interface cft_req_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

interface cft_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       field_end;
  logic       record_end;

  modport source (output valid, output out_char, output char_valid, output field_end,
                  output record_end, input ready);
  modport sink (input valid, input out_char, input char_valid, input field_end,
                input record_end, output ready);
endinterface

// File: rtl/cft_in_stage.sv
// Input register stage: captures one request per cycle unless a held request is not yet taken.
module cft_in_stage import cft_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cft_req_if.sink    req,
  input  logic       take_i,
  output logic       item_valid_o,
  output item_t      item_o
);

  logic  valid_q;
  item_t item_q;
  logic  accept;

  assign req.ready    = !valid_q || take_i;
  assign accept       = req.valid && req.ready;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{cmd: req.cmd, data_byte: req.data_byte};
    end
  end

  a_take_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> valid_q) else $error("take without a held request");

  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req.ready |-> valid_q) else $error("input stalled while empty");

endmodule

// File: rtl/cft_decode.sv
// Quote mode state and per-byte decode into a field result.
module cft_decode import cft_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  item_t      item_i,
  input  logic       can_load_i,
  input  logic [7:0] delimiter_i,
  output logic       take_o,
  output logic       res_valid_o,
  output result_t    res_o
);

  quote_mode_e mode_q, mode_d;
  logic        has_res;
  logic        as_outside;
  logic        is_quote;
  result_t     res;

  assign take_o   = item_valid_i && can_load_i;
  assign is_quote = (item_i.data_byte == QUOTE_BYTE);

  always_comb begin
    mode_d     = mode_q;
    res        = '0;
    has_res    = 1'b0;
    as_outside = 1'b0;
    if (item_i.cmd == CMD_EOR) begin
      mode_d         = MODE_OUTSIDE;
      res.field_end  = 1'b1;
      res.record_end = 1'b1;
      has_res        = 1'b1;
    end else begin
      case (mode_q)
        MODE_INSIDE: begin
          if (is_quote) begin
            mode_d = MODE_PENDING;
          end else begin
            res.out_char   = item_i.data_byte;
            res.char_valid = 1'b1;
            has_res        = 1'b1;
          end
        end
        MODE_PENDING: begin
          if (is_quote) begin
            // doubled quote: emit one literal quote
            mode_d         = MODE_INSIDE;
            res.out_char   = QUOTE_BYTE;
            res.char_valid = 1'b1;
            has_res        = 1'b1;
          end else begin
            mode_d     = MODE_OUTSIDE;
            as_outside = 1'b1;
          end
        end
        default: begin
          if (is_quote) begin
            mode_d = MODE_INSIDE;
          end else begin
            mode_d     = MODE_OUTSIDE;
            as_outside = 1'b1;
          end
        end
      endcase
      if (as_outside) begin
        has_res = 1'b1;
        if (item_i.data_byte == delimiter_i) begin
          res.field_end = 1'b1;
        end else begin
          res.out_char   = item_i.data_byte;
          res.char_valid = 1'b1;
        end
      end
    end
  end

  assign res_valid_o = take_o && has_res;
  assign res_o       = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_OUTSIDE;
    end else if (take_o) begin
      mode_q <= mode_d;
    end
  end

  a_field_end_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.field_end |-> !res_o.char_valid && (res_o.out_char == 8'd0))
    else $error("field end carries a character");

  a_eor_to_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && (item_i.cmd == CMD_EOR) |=> mode_q == MODE_OUTSIDE)
    else $error("end of record left quoting open");

  a_quote_not_passed_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && (item_i.cmd == CMD_BYTE) && is_quote && (mode_q != MODE_PENDING)
      |-> !res_valid_o)
    else $error("quote byte produced a result");

endmodule

// File: rtl/cft_out_stage.sv
// Result register stage driving the result channel.
module cft_out_stage import cft_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       res_valid_i,
  input  result_t    res_i,
  output logic       can_load_o,
  cft_rsp_if.source  rsp
);

  logic    valid_q;
  result_t res_q;

  assign can_load_o     = !valid_q || rsp.ready;
  assign rsp.valid      = valid_q;
  assign rsp.out_char   = res_q.out_char;
  assign rsp.char_valid = res_q.char_valid;
  assign rsp.field_end  = res_q.field_end;
  assign rsp.record_end = res_q.record_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  a_record_end_has_field_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && res_q.record_end |-> res_q.field_end)
    else $error("record end without field end");

  a_no_load_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> can_load_o) else $error("result offered while output full");

endmodule

// File: rtl/csv_field_tokenizer_top.sv
// CSV field tokenizer top level: request register, quote decode, result register.
// Takes one record byte or end-of-record request per cycle and returns at most one
// result per request, via both registers: a field byte, a field end, or a field end
// flagged as record end. Quotes open and close quoting and are never passed on;
// a doubled quote inside quotes yields one literal quote. The sustained rate is one
// request per clock, set by the single quote-mode register updated as each request
// leaves the input register; stalls on the result channel hold both stages.
// The delimiter register resets to comma and may be written only while idle.
module csv_field_tokenizer_top import cft_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       delim_we_i,
  input  logic [7:0] delim_wdata_i,
  cft_req_if.sink    req_i,
  cft_rsp_if.source  rsp_o
);

  logic [7:0] delimiter_q;
  logic       item_valid;
  item_t      item;
  logic       take;
  logic       can_load;
  logic       res_valid;
  result_t    res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delimiter_q <= DELIM_RESET;
    end else if (delim_we_i) begin
      delimiter_q <= delim_wdata_i;
    end
  end

  cft_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  cft_decode u_dec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .can_load_i   (can_load),
    .delimiter_i  (delimiter_q),
    .take_o       (take),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  cft_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .can_load_o  (can_load),
    .rsp         (rsp_o)
  );

endmodule

// File: verif/tb.sv
// Self-checking testbench for the CSV field tokenizer: random records, stalls, delimiter sweeps.
module tb;
  import cft_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 230;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 8;

  typedef enum int {
    RX_FREE,
    RX_RANDOM,
    RX_SHORT,
    RX_LONG
  } rx_style_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       delim_we    = 1'b0;
  logic [7:0] delim_wdata = '0;
  logic       req_valid   = 1'b0;
  logic       req_cmd     = 1'b0;
  logic [7:0] req_byte    = '0;
  logic       rsp_ready   = 1'b0;

  cft_req_if req_bus ();
  cft_rsp_if rsp_bus ();

  assign req_bus.valid     = req_valid;
  assign req_bus.cmd       = req_cmd;
  assign req_bus.data_byte = req_byte;
  assign rsp_bus.ready     = rsp_ready;

  csv_field_tokenizer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .delim_we_i    (delim_we),
    .delim_wdata_i (delim_wdata),
    .req_i         (req_bus),
    .rsp_o         (rsp_bus)
  );

  // Tokenizer state as the testbench sees it
  quote_mode_e tok_mode  = MODE_OUTSIDE;
  logic [7:0]  tok_delim = DELIM_RESET;

  item_t   byte_q[$];
  result_t token_q[$];

  int        queued_cnt   = 0;
  int        mismatch_cnt = 0;
  int        idle_cycles  = 0;
  bit        req_took     = 1'b0;
  int        burst_left   = 1;
  int        gap_left     = 0;
  rx_style_e stall_style  = RX_FREE;
  int        stall_tick   = 0;
  int        hold_left    = 0;
  bit        hold_req     = 1'b0;
  bit        hold_done    = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit tokenize_step(input item_t it, output result_t res);
    logic [7:0] b;
    b = it.data_byte;
    res = '0;
    if (it.cmd == CMD_EOR) begin
      tok_mode = MODE_OUTSIDE;
      res.field_end = 1'b1;
      res.record_end = 1'b1;
      return 1'b1;
    end
    if (tok_mode == MODE_INSIDE) begin
      if (b == QUOTE_BYTE) begin
        tok_mode = MODE_PENDING;
        return 1'b0;
      end
      res.out_char = b;
      res.char_valid = 1'b1;
      return 1'b1;
    end
    if (tok_mode == MODE_PENDING && b == QUOTE_BYTE) begin
      tok_mode = MODE_INSIDE;
      res.out_char = QUOTE_BYTE;
      res.char_valid = 1'b1;
      return 1'b1;
    end
    if (tok_mode != MODE_PENDING && b == QUOTE_BYTE) begin
      tok_mode = MODE_INSIDE;
      return 1'b0;
    end
    // Pending with a non-quote byte closes quoting; handle as outside
    tok_mode = MODE_OUTSIDE;
    if (b == tok_delim) begin
      res.field_end = 1'b1;
    end else begin
      res.out_char = b;
      res.char_valid = 1'b1;
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  // Sample both channels and the register write at the rising edge
  always @(posedge clk_i) begin
    item_t   taken;
    result_t res;
    result_t want;
    req_took = req_valid && (req_bus.ready === 1'b1);
    if (rst_ni && delim_we) begin
      tok_delim = delim_wdata;
    end
    if ((rsp_bus.valid === 1'b1) && rsp_ready) begin
      if (token_q.size() == 0) begin
        $error("result with nothing pending: out_char %0h char_valid %0b field_end %0b",
               rsp_bus.out_char, rsp_bus.char_valid, rsp_bus.field_end);
        mismatch_cnt++;
      end else begin
        want = token_q.pop_front();
        check_field("out_char", want.out_char, rsp_bus.out_char);
        check_field("char_valid", 8'(want.char_valid), 8'(rsp_bus.char_valid));
        check_field("field_end", 8'(want.field_end), 8'(rsp_bus.field_end));
        check_field("record_end", 8'(want.record_end), 8'(rsp_bus.record_end));
      end
    end
    if (req_took) begin
      taken = byte_q.pop_front();
      if (tokenize_step(taken, res)) begin
        token_q = {token_q, res};
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_valid && (req_bus.ready === 1'b1)) || ((rsp_bus.valid === 1'b1) && rsp_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Request driver: bursts of random length, random gaps, hold until taken
  always @(negedge clk_i) begin
    item_t head;
    if (!(req_valid && !req_took)) begin
      if (gap_left > 0) begin
        req_valid <= 1'b0;
        gap_left--;
      end else if (byte_q.size() > 0) begin
        head = byte_q[0];
        req_valid <= 1'b1;
        req_cmd <= head.cmd;
        req_byte <= head.data_byte;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result receiver: switch stall pattern now and then, one long hold on request
  always @(negedge clk_i) begin
    stall_tick++;
    if (stall_tick % 80 == 0) begin
      stall_style = rx_style_e'($urandom_range(0, 3));
    end
    if (hold_left > 0) begin
      rsp_ready <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
      rsp_ready <= 1'b0;
    end else begin
      case (stall_style)
        RX_FREE:   rsp_ready <= 1'b1;
        RX_RANDOM: rsp_ready <= ($urandom_range(0, 99) >= 40);
        RX_SHORT:  rsp_ready <= (stall_tick % 5 < 3);
        default:   rsp_ready <= (stall_tick % 16 >= 9);
      endcase
    end
  end

  task automatic push_item(input cmd_e c, input logic [7:0] b);
    item_t it;
    it.cmd = c;
    it.data_byte = b;
    byte_q = {byte_q, it};
    queued_cnt++;
  endtask

  function automatic logic [7:0] plain_byte(input logic [7:0] d);
    logic [7:0] b;
    b = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(32, 126));
    while (b == QUOTE_BYTE || b == d) begin
      b = 8'($urandom_range(0, 255));
    end
    return b;
  endfunction

  task automatic add_record(input logic [7:0] d);
    int         nfields;
    int         len;
    int         r;
    logic [7:0] b;
    nfields = $urandom_range(1, 5);
    for (int f = 0; f < nfields; f++) begin
      if (f > 0) begin
        push_item(CMD_BYTE, d);
      end
      len = $urandom_range(0, 6);
      if ($urandom_range(0, 2) == 0) begin
        push_item(CMD_BYTE, QUOTE_BYTE);
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(0, 9);
          if (r < 2) begin
            push_item(CMD_BYTE, QUOTE_BYTE);
            push_item(CMD_BYTE, QUOTE_BYTE);
          end else if (r == 2) begin
            push_item(CMD_BYTE, d);
          end else begin
            b = 8'($urandom_range(0, 255));
            if (b == QUOTE_BYTE) b = 8'h00;
            push_item(CMD_BYTE, b);
          end
        end
        // Leave some quoted fields open, trail others with stray bytes
        if ($urandom_range(0, 9) != 0) begin
          push_item(CMD_BYTE, QUOTE_BYTE);
          if ($urandom_range(0, 7) == 0) push_item(CMD_BYTE, plain_byte(d));
        end
      end else begin
        for (int k = 0; k < len; k++) begin
          push_item(CMD_BYTE, plain_byte(d));
        end
      end
    end
    push_item(CMD_EOR, 8'($urandom_range(0, 255)));
  endtask

  task automatic add_noise(input logic [7:0] d);
    int n;
    int r;
    n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 11);
      if (r < 2) push_item(CMD_EOR, 8'($urandom_range(0, 255)));
      else if (r < 5) push_item(CMD_BYTE, QUOTE_BYTE);
      else if (r < 6) push_item(CMD_BYTE, d);
      else push_item(CMD_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic fill_random(input logic [7:0] d, input int n);
    int target;
    target = queued_cnt + n;
    while (queued_cnt < target) begin
      if ($urandom_range(0, 9) < 8) add_record(d);
      else add_noise(d);
    end
  endtask

  // Delimiter is still the reset comma here
  task automatic load_directed();
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_BYTE, 8'hFF);
    push_item(CMD_BYTE, DELIM_RESET);
    push_item(CMD_BYTE, QUOTE_BYTE);
    push_item(CMD_BYTE, DELIM_RESET);
    push_item(CMD_BYTE, QUOTE_BYTE);
    push_item(CMD_BYTE, QUOTE_BYTE);
    push_item(CMD_BYTE, 8'h71);
    push_item(CMD_BYTE, QUOTE_BYTE);
    push_item(CMD_BYTE, DELIM_RESET);
    push_item(CMD_EOR, 8'hFF);
    push_item(CMD_EOR, 8'h00);
    push_item(CMD_BYTE, QUOTE_BYTE);
    push_item(CMD_BYTE, 8'h41);
    push_item(CMD_EOR, QUOTE_BYTE);
    push_item(CMD_BYTE, QUOTE_BYTE);
    push_item(CMD_BYTE, 8'h7A);
    push_item(CMD_BYTE, QUOTE_BYTE);
    push_item(CMD_EOR, 8'h00);
    push_item(CMD_BYTE, QUOTE_BYTE);
    push_item(CMD_BYTE, QUOTE_BYTE);
    push_item(CMD_BYTE, 8'h61);
    push_item(CMD_EOR, 8'h80);
  endtask

  task automatic drain();
    while (byte_q.size() != 0 || req_valid || token_q.size() != 0) begin
      @(posedge clk_i);
    end
    // Let any request that makes no result clear the pipeline
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_delim(input logic [7:0] v);
    @(negedge clk_i);
    delim_we = 1'b1;
    delim_wdata = v;
    @(negedge clk_i);
    delim_we = 1'b0;
  endtask

  initial begin
    logic [7:0] delim_plan [7];
    delim_plan = '{8'd44, 8'd59, 8'd0, 8'd255, QUOTE_BYTE, 8'd9, 8'd0};
    delim_plan[6] = 8'($urandom_range(0, 255));
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    load_directed();
    drain();
    foreach (delim_plan[i]) begin
      write_delim(delim_plan[i]);
      if (i == 1) hold_req = 1'b1;
      fill_random(delim_plan[i], PHASE_ITEMS);
      drain();
    end
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/cft_pkg.sv
rtl/cft_stream_if.sv
rtl/cft_in_stage.sv
rtl/cft_decode.sv
rtl/cft_out_stage.sv
rtl/csv_field_tokenizer_top.sv
verif/tb.sv
